### rtl/fdmd_pkg.sv
package fdmd_pkg;

   // Field widths of the pixel and result transactions.
   localparam int PIX_W  = 8;
   localparam int TIME_W = 48;
   localparam int SLOT_W = 16;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int THR_W      = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION  = 2'd2;

   localparam logic [CSR_DATA_W-1:0] INTERVAL_RESET = 32'd1000;
   localparam logic [CSR_DATA_W-1:0] DURATION_RESET = 32'd5000;

   // The threshold is held premultiplied by full scale (255).
   localparam int THR255_W = THR_W + 8;
   localparam logic [THR255_W-1:0] THR255_RESET = 25'd167025;

   // Frame bookkeeping that travels with a transaction down the pipeline.
   typedef struct packed {
      logic abandon;    // an unfinished taken frame was cut off by a new frame
      logic frame_end;  // last pixel of a taken frame
      logic oversize;   // the frame ran past the store depth
   } fdmd_ctl_type;

endpackage

### rtl/fdmd_req_if.sv
interface fdmd_req_if;
   import fdmd_pkg::*;

   logic              valid;
   logic              ready;
   logic [PIX_W-1:0]  luma_pixel;
   logic              first_pixel;
   logic              last_pixel;
   logic [TIME_W-1:0] frame_time_ms;
   logic [SLOT_W-1:0] slot_number;

   modport source (
      output valid, luma_pixel, first_pixel, last_pixel, frame_time_ms, slot_number,
      input  ready
   );

   modport sink (
      input  valid, luma_pixel, first_pixel, last_pixel, frame_time_ms, slot_number,
      output ready
   );

endinterface

### rtl/fdmd_rsp_if.sv
interface fdmd_rsp_if;
   import fdmd_pkg::*;

   logic              valid;
   logic              ready;
   logic              pass_frame;
   logic              event_start;
   logic              event_stop;
   logic [SLOT_W-1:0] event_slot;
   logic [TIME_W-1:0] event_time_ms;

   modport source (
      output valid, pass_frame, event_start, event_stop, event_slot, event_time_ms,
      input  ready
   );

   modport sink (
      input  valid, pass_frame, event_start, event_stop, event_slot, event_time_ms,
      output ready
   );

endinterface

### rtl/fdmd_frame_ram.sv
module fdmd_frame_ram #(
   parameter int DEPTH  = 1048576,
   parameter int ADDR_W = 20
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [fdmd_pkg::PIX_W-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [fdmd_pkg::PIX_W-1:0] wr_data
);
   import fdmd_pkg::*;

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   // Read returns the contents from before a write at the same edge.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fdmd_decide.sv
module fdmd_decide #(
   parameter int CNT_W  = 21,
   parameter int SUM_W  = 29,
   parameter int PROD_W = 46
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  fdmd_pkg::fdmd_ctl_type          in_ctl,
   input  logic [CNT_W-1:0]                in_count,
   input  logic [SUM_W-1:0]                in_sum,
   input  logic [PROD_W-1:0]               in_limit,
   input  logic [fdmd_pkg::TIME_W-1:0]     in_time,
   input  logic [fdmd_pkg::SLOT_W-1:0]     in_slot,
   input  logic [fdmd_pkg::CSR_DATA_W-1:0] duration,
   output logic                            advance,
   fdmd_rsp_if.source                      rsp_chan
);
   import fdmd_pkg::*;

   // Decision stage registers.
   logic               s2_valid_ff;
   fdmd_ctl_type       s2_ctl_ff;
   logic [CNT_W-1:0]   s2_count_ff;
   logic [SUM_W-1:0]   s2_sum_ff;
   logic [PROD_W-1:0]  s2_limit_ff;
   logic [TIME_W-1:0]  s2_time_ff;
   logic [SLOT_W-1:0]  s2_slot_ff;

   // Cache and event state.
   logic               cache_valid_ff, cache_valid_in;
   logic [CNT_W-1:0]   cached_count_ff, cached_count_in;
   logic               event_open_ff, event_open_in;
   logic [TIME_W-1:0]  event_time_ff, event_time_in;

   // Result register.
   logic               rsp_valid_ff;
   logic               rsp_pass_ff, rsp_start_ff, rsp_stop_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic [TIME_W-1:0]  rsp_time_ff;

   logic               cache_ok;
   logic               judge;
   logic               moving;
   logic               aged;
   logic               emit;
   logic               pass_bit, start_bit, stop_bit;
   logic [PROD_W-1:0]  scaled_sum;
   logic [TIME_W-1:0]  event_age;

   assign scaled_sum = {1'b0, s2_sum_ff, 16'b0};
   assign moving     = scaled_sum >= s2_limit_ff;
   assign event_age  = s2_time_ff - event_time_ff;
   assign aged       = event_age >= {16'b0, duration};

   always_comb begin
      cache_ok        = s2_ctl_ff.abandon ? 1'b0 : cache_valid_ff;
      judge           = s2_valid_ff && s2_ctl_ff.frame_end && !s2_ctl_ff.oversize &&
                        cache_ok && (s2_count_ff == cached_count_ff);
      emit            = judge && (moving || event_open_ff);
      pass_bit        = moving || !aged;
      start_bit       = moving && !event_open_ff;
      stop_bit        = !moving && aged;
      advance         = !(emit && rsp_valid_ff && !rsp_chan.ready);

      cache_valid_in  = cache_ok;
      cached_count_in = cached_count_ff;
      event_open_in   = event_open_ff;
      event_time_in   = event_time_ff;
      if (s2_ctl_ff.frame_end) begin
         if (s2_ctl_ff.oversize) begin
            cache_valid_in = 1'b0;
         end else if (!judge) begin
            cache_valid_in  = 1'b1;
            cached_count_in = s2_count_ff;
         end
      end
      if (judge && moving && !event_open_ff) begin
         event_open_in = 1'b1;
         event_time_in = s2_time_ff;
      end else if (judge && !moving && event_open_ff && aged) begin
         event_open_in = 1'b0;
         event_time_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff     <= 1'b0;
         cache_valid_ff  <= 1'b0;
         cached_count_ff <= '0;
         event_open_ff   <= 1'b0;
         event_time_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (advance) begin
            s2_valid_ff <= in_valid;
            if (s2_valid_ff) begin
               cache_valid_ff  <= cache_valid_in;
               cached_count_ff <= cached_count_in;
               event_open_ff   <= event_open_in;
               event_time_ff   <= event_time_in;
            end
         end
         if (advance && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         s2_ctl_ff   <= in_ctl;
         s2_count_ff <= in_count;
         s2_sum_ff   <= in_sum;
         s2_limit_ff <= in_limit;
         s2_time_ff  <= in_time;
         s2_slot_ff  <= in_slot;
      end
      if (advance && emit) begin
         rsp_pass_ff  <= pass_bit;
         rsp_start_ff <= start_bit;
         rsp_stop_ff  <= stop_bit;
         rsp_slot_ff  <= s2_slot_ff;
         rsp_time_ff  <= s2_time_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pass_frame    = rsp_pass_ff;
   assign rsp_chan.event_start   = rsp_start_ff;
   assign rsp_chan.event_stop    = rsp_stop_ff;
   assign rsp_chan.event_slot    = rsp_slot_ff;
   assign rsp_chan.event_time_ms = rsp_time_ff;

endmodule

### rtl/frame_difference_motion_detector.sv
// Throughput: one pixel transaction per clock cycle while the input is not stalled,
// sustained across frame boundaries. After a frame's last pixel is accepted, its result
// passes the store read and difference stage, decision stage and result register.
// Input stalls only while a new result meets an untaken one in the result register.
// Reset (synchronous, active high) clears all control and event state and loads the
// register defaults; the frame store is not cleared and holds no data until written.
module frame_difference_motion_detector #(
   parameter int MAX_PIXELS = 1048576
) (
   input  logic                                clock,
   input  logic                                reset,
   fdmd_req_if.sink                            req_chan,
   fdmd_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [fdmd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fdmd_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import fdmd_pkg::*;

   // The pixel counter must hold one count beyond the store depth so that an
   // oversize frame can be recognized at its last pixel.
   localparam int CNT_W  = $clog2(MAX_PIXELS + 2);
   localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int SUM_W  = CNT_W + PIX_W;
   localparam int PROD_W = CNT_W + THR255_W;

   // Configuration registers. The threshold is stored already scaled by 255,
   // so the decision needs only one multiplication by the pixel count.
   logic [CSR_DATA_W-1:0] interval_ff;
   logic [THR255_W-1:0]   thr255_ff;
   logic [CSR_DATA_W-1:0] duration_ff;
   logic [THR255_W-1:0]   thr255_in;

   assign thr255_in = {csr_wr_data[THR_W-1:0], 8'b0} - {8'b0, csr_wr_data[THR_W-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
         thr255_ff   <= THR255_RESET;
         duration_ff <= DURATION_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_INTERVAL:  interval_ff <= csr_wr_data;
            CSR_THRESHOLD: thr255_ff   <= thr255_in;
            CSR_DURATION:  duration_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pixel stage. Frame tracking happens as a transaction is accepted: the
   // first pixel decides whether the frame is taken, and every pixel of a
   // taken frame gets its store address from the pixel counter.
   // ------------------------------------------------------------------------
   logic                advance;
   logic                accept;

   logic                in_frame_ff, in_frame_in;
   logic                taken_ff, taken_in;
   logic                time_valid_ff, time_valid_in;
   logic [TIME_W-1:0]   last_time_ff, last_time_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   logic [CNT_W-1:0]    count_base;
   logic [TIME_W-1:0]   time_gap;
   logic                access;
   fdmd_ctl_type        ctl;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = advance;
   assign time_gap       = req_chan.frame_time_ms - last_time_ff;

   always_comb begin
      in_frame_in   = in_frame_ff;
      taken_in      = taken_ff;
      time_valid_in = time_valid_ff;
      last_time_in  = last_time_ff;
      count_base    = count_ff;
      access        = 1'b0;
      ctl           = '0;

      if (req_chan.first_pixel) begin
         // A new frame cuts off any frame still streaming.
         ctl.abandon = in_frame_ff && taken_ff;
         in_frame_in = 1'b1;
         count_base  = '0;
         taken_in    = 1'b0;
         if (!time_valid_ff) begin
            // The very first frame only records its time.
            time_valid_in = 1'b1;
            last_time_in  = req_chan.frame_time_ms;
         end else if (req_chan.frame_time_ms >= last_time_ff &&
                      time_gap >= {16'b0, interval_ff}) begin
            last_time_in = req_chan.frame_time_ms;
            taken_in     = 1'b1;
         end
      end

      count_in = count_base;
      if (in_frame_in && taken_in) begin
         access = count_base < CNT_W'(MAX_PIXELS);
         if (count_base <= CNT_W'(MAX_PIXELS)) begin
            count_in = count_base + CNT_W'(1);
         end
      end

      if (in_frame_in && req_chan.last_pixel) begin
         in_frame_in   = 1'b0;
         ctl.frame_end = taken_in;
         ctl.oversize  = count_in > CNT_W'(MAX_PIXELS);
         taken_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         taken_ff      <= 1'b0;
         time_valid_ff <= 1'b0;
         last_time_ff  <= '0;
         count_ff      <= '0;
      end else if (accept) begin
         in_frame_ff   <= in_frame_in;
         taken_ff      <= taken_in;
         time_valid_ff <= time_valid_in;
         last_time_ff  <= last_time_in;
         count_ff      <= count_in;
      end
   end

   // ------------------------------------------------------------------------
   // Difference stage. The store read issued at acceptance returns here; the
   // absolute difference is summed and the new pixel is written back at the
   // same address. The only overlap on one address is the first pixel of a frame
   // that has no second pixel being written while the next frame reads entry zero,
   // so the write data is forwarded for that case.
   // ------------------------------------------------------------------------
   logic                s1_valid_ff;
   logic                s1_first_ff;
   logic                s1_access_ff;
   fdmd_ctl_type        s1_ctl_ff;
   logic [CNT_W-1:0]    s1_count_ff;
   logic [TIME_W-1:0]   s1_time_ff;
   logic [SLOT_W-1:0]   s1_slot_ff;
   logic [PIX_W-1:0]    s1_pix_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic                s1_fwd_ff;
   logic [PIX_W-1:0]    s1_fwd_pix_ff;

   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [ADDR_W-1:0]   rd_addr;
   logic                s1_write;
   logic                fwd_in;
   logic [PIX_W-1:0]    ram_rd_data;
   logic [PIX_W-1:0]    old_pix;
   logic [PIX_W-1:0]    abs_diff;
   logic [SUM_W-1:0]    sum_base;
   logic [PROD_W-1:0]   limit;

   assign rd_addr  = count_base[ADDR_W-1:0];
   assign s1_write = advance && s1_valid_ff && s1_access_ff;
   assign fwd_in   = s1_write && (s1_addr_ff == rd_addr);

   fdmd_frame_ram #(
      .DEPTH  (MAX_PIXELS),
      .ADDR_W (ADDR_W)
   ) u_frame_ram (
      .clock   (clock),
      .rd_en   (accept && access),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (s1_write),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_pix_ff)
   );

   assign old_pix  = s1_fwd_ff ? s1_fwd_pix_ff : ram_rd_data;
   assign abs_diff = (old_pix >= s1_pix_ff) ? (old_pix - s1_pix_ff) : (s1_pix_ff - old_pix);
   assign sum_base = s1_first_ff ? '0 : sum_ff;
   assign sum_in   = s1_access_ff ? (sum_base + SUM_W'(abs_diff)) : sum_base;

   // Motion limit: threshold times 255 times the pixel count, registered in
   // the decision stage before the compare.
   assign limit    = PROD_W'(thr255_ff) * PROD_W'(s1_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         sum_ff      <= '0;
      end else if (advance) begin
         s1_valid_ff <= accept;
         if (s1_valid_ff) begin
            sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_first_ff   <= req_chan.first_pixel;
         s1_access_ff  <= access;
         s1_ctl_ff     <= ctl;
         s1_count_ff   <= count_in;
         s1_time_ff    <= last_time_in;
         s1_slot_ff    <= req_chan.slot_number;
         s1_pix_ff     <= req_chan.luma_pixel;
         s1_addr_ff    <= rd_addr;
         s1_fwd_ff     <= fwd_in;
         s1_fwd_pix_ff <= s1_pix_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Decision stage and result register: cache check, movement compare and
   // event tracking. It also produces the pipeline advance.
   // ------------------------------------------------------------------------
   fdmd_decide #(
      .CNT_W  (CNT_W),
      .SUM_W  (SUM_W),
      .PROD_W (PROD_W)
   ) u_decide (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .in_ctl   (s1_ctl_ff),
      .in_count (s1_count_ff),
      .in_sum   (sum_in),
      .in_limit (limit),
      .in_time  (s1_time_ff),
      .in_slot  (s1_slot_ff),
      .duration (duration_ff),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   // The pipeline may only hold back while a result is waiting to be taken.
   assert property (@(posedge clock) disable iff (reset)
      !advance |-> rsp_chan.valid)
      else $error("pipeline stalled with no result pending");

   // The pixel counter saturates one past the store depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PIXELS + 1))
      else $error("pixel counter ran past its limit");

   // A held difference stage keeps its store address and pixel.
   assert property (@(posedge clock) disable iff (reset)
      (!advance && s1_valid_ff) |=> (s1_valid_ff && $stable(s1_addr_ff) &&
                                     $stable(s1_pix_ff)))
      else $error("difference stage changed while stalled");
`endif

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for frame_difference_motion_detector.
//
// The block is built with a four-pixel frame store so that every frame stays short and
// oversize frames are cheap to make. A scoreboard object mirrors the detector state
// (frame store, pixel-count cache, last taken time, open event). It notes every pixel
// transaction the block accepts and builds the expected result of each frame that gives
// one. Result transactions are compared in order, one field at a time.
module testbench;
   import fdmd_pkg::*;

   // Store depth handed to the block. The predictor uses the same value.
   localparam int FRAME_DEPTH = 4;
   // Random pixel transactions that lie inside frames.
   localparam int ITEM_TARGET = 1600;
   // The settle time gives the block room to report a result after the last pixel,
   // before registers change or the run ends.
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_DATA_W-1:0] THRESHOLD_RESET = 32'd655;
   localparam logic [TIME_W-1:0] BASE_TIME = 48'h0000_0001_0000;

   typedef struct packed {
      logic              pass_frame;
      logic              event_start;
      logic              event_stop;
      logic [SLOT_W-1:0] event_slot;
      logic [TIME_W-1:0] event_time_ms;
   } decision_type;

   // The ways a frame's pixels are chosen, some of them from the previous frame sent.
   typedef enum {FILL_HOLD, FILL_JITTER, FILL_RANDOM, FILL_INVERT, FILL_ZERO, FILL_FULL}
      fill_style_type;

   // Tracks the detector state and holds the decisions that are still to arrive.
   class motion_decision_tracker;
      logic [PIX_W-1:0]      prior_frame [FRAME_DEPTH];
      bit                    cache_ok, time_seen, event_active, streaming, taken;
      int unsigned           cached_count, pixel_index;
      logic [TIME_W-1:0]     last_time, open_time;
      longint unsigned       diff_sum;
      logic [CSR_DATA_W-1:0] interval_ms, duration_ms;
      logic [THR_W-1:0]      threshold_q16;
      decision_type          expected_decisions [$];
      int errors, reported, checked, starts, stops, passes;
      int frames_begun, frames_cut, frames_oversize;

      function new();
         foreach (prior_frame[i]) prior_frame[i] = '0;
         last_time = '0;
         open_time = '0;
         interval_ms = INTERVAL_RESET;
         threshold_q16 = THRESHOLD_RESET[THR_W-1:0];
         duration_ms = DURATION_RESET;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_INTERVAL:  interval_ms = value;
            CSR_THRESHOLD: threshold_q16 = value[THR_W-1:0];
            CSR_DURATION:  duration_ms = value;
            default: ;
         endcase
      endfunction

      function void note_pixel(logic [PIX_W-1:0] luma, logic first, logic last,
                               logic [TIME_W-1:0] stamp, logic [SLOT_W-1:0] slot);
         logic [PIX_W-1:0] old;
         longint unsigned  limit;
         bit               moving;
         decision_type     d;
         if (first) begin
            frames_begun++;
            // A frame cut off by a new first pixel leaves the store partly rewritten.
            if (streaming && taken) begin
               cache_ok = 0;
               frames_cut++;
            end
            streaming = 1;
            pixel_index = 0;
            diff_sum = 0;
            taken = 0;
            if (!time_seen) begin
               time_seen = 1;
               last_time = stamp;
            end else if (stamp >= last_time &&
                         (stamp - last_time) >= {16'b0, interval_ms}) begin
               last_time = stamp;
               taken = 1;
            end
         end
         if (!streaming) return;
         if (taken) begin
            if (pixel_index < FRAME_DEPTH) begin
               old = prior_frame[pixel_index];
               diff_sum += 64'((old >= luma) ? (old - luma) : (luma - old));
               prior_frame[pixel_index] = luma;
            end
            if (pixel_index <= FRAME_DEPTH) pixel_index++;
         end
         if (!last) return;
         streaming = 0;
         if (!taken) return;
         taken = 0;
         if (pixel_index > FRAME_DEPTH) begin
            cache_ok = 0;
            frames_oversize++;
            return;
         end
         if (!cache_ok || pixel_index != cached_count) begin
            cache_ok = 1;
            cached_count = pixel_index;
            return;
         end
         limit = 64'(threshold_q16) * 64'(255) * 64'(pixel_index);
         moving = (diff_sum << 16) >= limit;
         d = '0;
         d.event_slot = slot;
         d.event_time_ms = last_time;
         if (moving) begin
            if (!event_active) begin
               event_active = 1;
               open_time = last_time;
               d.event_start = 1;
               starts++;
            end
            d.pass_frame = 1;
         end else if (event_active && (last_time - open_time) >= {16'b0, duration_ms}) begin
            event_active = 0;
            open_time = '0;
            d.event_stop = 1;
            stops++;
         end else if (event_active) begin
            d.pass_frame = 1;
         end else begin
            return;
         end
         if (d.pass_frame) passes++;
         expected_decisions.push_back(d);
      endfunction

      function void check_decision(decision_type got);
         decision_type want;
         checked++;
         if (expected_decisions.size() == 0) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("unexpected result: pass=%0b start=%0b stop=%0b slot=%h time=%h",
                        got.pass_frame, got.event_start, got.event_stop, got.event_slot,
                        got.event_time_ms);
            end
            return;
         end
         want = expected_decisions.pop_front();
         if (got.pass_frame !== want.pass_frame || got.event_start !== want.event_start ||
             got.event_stop !== want.event_stop || got.event_slot !== want.event_slot ||
             got.event_time_ms !== want.event_time_ms) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("mismatch: expected pass=%0b start=%0b stop=%0b slot=%h time=%h",
                        want.pass_frame, want.event_start, want.event_stop, want.event_slot,
                        want.event_time_ms);
               $display("          actual   pass=%0b start=%0b stop=%0b slot=%h time=%h",
                        got.pass_frame, got.event_start, got.event_stop, got.event_slot,
                        got.event_time_ms);
            end
         end
      endfunction

      function void flush_expectations();
         if (expected_decisions.size() != 0) begin
            errors += expected_decisions.size();
            $display("%0d expected results never arrived", expected_decisions.size());
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   fdmd_req_if req_bus ();
   fdmd_rsp_if rsp_bus ();

   frame_difference_motion_detector #(
      .MAX_PIXELS (FRAME_DEPTH)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   motion_decision_tracker tracker = new();

   // Stimulus state that is shared by the driving tasks.
   int               burst_left = 0;
   bit               gaps_on = 1'b1;
   bit               hold_off_request = 1'b0;
   logic [TIME_W-1:0] stamp;
   int               random_pixels = 0;
   logic [PIX_W-1:0] scene [FRAME_DEPTH+2];
   int               cycle_count = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // The monitor samples both channels at the clock edge. Every input is driven with
   // nonblocking assignments, so it sees the values that were set up before the edge.
   // A result can never come in the same cycle as its own last pixel, so checking
   // before noting the input is safe.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            tracker.check_decision('{rsp_bus.pass_frame, rsp_bus.event_start,
                                     rsp_bus.event_stop, rsp_bus.event_slot,
                                     rsp_bus.event_time_ms});
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            tracker.note_pixel(req_bus.luma_pixel, req_bus.first_pixel, req_bus.last_pixel,
                               req_bus.frame_time_ms, req_bus.slot_number);
      end
   end

   // The receiver switches between random stall patterns. A hold-off request
   // from the sender forces a long stretch with ready low. The sender keeps offering
   // pixels during that stretch, so the result register fills and the block stalls its input.
   initial begin
      int mode;
      int left;
      int hold;
      mode = 0;
      left = 0;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold = 400;
            hold_off_request = 1'b0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 200);
         end
         left--;
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_bus.ready <= 1'($urandom_range(0, 1));
               default: rsp_bus.ready <= ((left % 5) >= 2);
            endcase
         end
      end
   end

   // The watchdog ends a hung run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: done, errors");
      $finish;
   end

   // Offers one pixel transaction and returns at the edge where it is accepted. The
   // sender works in bursts. Between bursts, valid drops for a random pause if gaps are on.
   task automatic send_pixel(input logic [PIX_W-1:0] luma, input logic first,
                             input logic last, input logic [TIME_W-1:0] t,
                             input logic [SLOT_W-1:0] slot);
      if (burst_left == 0) begin
         if (gaps_on) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_bus.valid         <= 1'b1;
      req_bus.luma_pixel    <= luma;
      req_bus.first_pixel   <= first;
      req_bus.last_pixel    <= last;
      req_bus.frame_time_ms <= t;
      req_bus.slot_number   <= slot;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      burst_left--;
   endtask

   // Sends one frame. Its pixels follow from the previous frame sent, according to the fill
   // style. Without close, the frame has no last pixel and the next frame cuts it off.
   task automatic send_frame(input logic [TIME_W-1:0] t, input logic [SLOT_W-1:0] slot,
                             input int len, input fill_style_type fill, input bit close);
      int v;
      for (int i = 0; i < len; i++) begin
         case (fill)
            FILL_HOLD:   v = scene[i];
            FILL_JITTER: v = int'(scene[i]) + int'($urandom_range(0, 6)) - 3;
            FILL_RANDOM: v = $urandom_range(0, 255);
            FILL_INVERT: v = 255 - int'(scene[i]);
            FILL_ZERO:   v = 0;
            default:     v = 255;
         endcase
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         scene[i] = v[PIX_W-1:0];
         send_pixel(v[PIX_W-1:0], i == 0, close && (i == len - 1), t, slot);
      end
   endtask

   // Drops valid and waits until every expected result has been taken. The first edge
   // lets the monitor note the pixel that was just accepted. Then it waits the extra
   // cycles it is given, so that frames that give no result also leave the pipeline.
   task automatic drain_results(input int extra);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tracker.expected_decisions.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      tracker.write_register(index, value);
      @(posedge clock);
   endtask

   task automatic program_registers(input logic [CSR_DATA_W-1:0] interval,
                                    input logic [CSR_DATA_W-1:0] threshold,
                                    input logic [CSR_DATA_W-1:0] duration);
      drain_results(SETTLE_CYCLES);
      write_register(CSR_INTERVAL, interval);
      write_register(CSR_THRESHOLD, threshold);
      write_register(CSR_DURATION, duration);
      csr_wr_en <= 1'b0;
   endtask

   // Picks the time of the next frame. Most frames come just after the interval, so they
   // are taken. Some come one millisecond early, some go back in time, and some jump far ahead.
   function automatic logic [TIME_W-1:0] next_stamp();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         stamp = stamp + TIME_W'(tracker.interval_ms) + TIME_W'($urandom_range(0, 3));
      else if (r < 80)
         stamp = (tracker.interval_ms == 0) ? stamp :
                 stamp + TIME_W'(tracker.interval_ms) - TIME_W'(1);
      else if (r < 88 && stamp > 2000)
         return stamp - TIME_W'($urandom_range(1, 2000));
      else
         stamp = stamp + TIME_W'($urandom);
      return stamp;
   endfunction

   // A run of random frames. The size of a frame usually stays the same from one frame
   // to the next, so that the pixel-count cache matches and decisions are made. The
   // other frames are stray pixels outside a frame, oversize frames, frames that are
   // cut off, and pauses where the sender waits for all results.
   task automatic run_frames(input int frames, input bit gaps);
      int             r;
      int             len;
      int             size;
      bit             close;
      bit             frame_open;
      fill_style_type fill;
      gaps_on = gaps;
      len = $urandom_range(1, FRAME_DEPTH);
      frame_open = 1'b0;
      for (int f = 0; f < frames; f++) begin
         r = $urandom_range(0, 99);
         if (!frame_open && r < 6)
            send_pixel(PIX_W'($urandom), 1'b0, 1'($urandom), {16'($urandom), 32'($urandom)},
                       SLOT_W'($urandom));
         else if (r < 20)
            len = $urandom_range(1, FRAME_DEPTH);
         else if (r < 23)
            drain_results(0);
         size = len;
         close = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 4) begin
            size = FRAME_DEPTH + $urandom_range(1, 2);
         end else if (r < 8 && f != frames - 1) begin
            size = $urandom_range(1, len);
            close = 1'b0;
         end
         r = $urandom_range(0, 99);
         if (r < 35)      fill = FILL_HOLD;
         else if (r < 75) fill = FILL_JITTER;
         else if (r < 92) fill = FILL_RANDOM;
         else             fill = FILL_INVERT;
         send_frame(next_stamp(), SLOT_W'($urandom), size, fill, close);
         random_pixels += size;
         frame_open = !close;
      end
   endtask

   initial begin
      int  phase;
      bit  high_time_done;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_INTERVAL;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.luma_pixel = '0;
      req_bus.first_pixel = 1'b0;
      req_bus.last_pixel = 1'b0;
      req_bus.frame_time_ms = '0;
      req_bus.slot_number = '0;
      foreach (scene[i]) scene[i] = PIX_W'($urandom);
      high_time_done = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the registers at their reset values (interval 1000 ms,
      // duration 5000 ms). A stray pixel that carries the largest time must be ignored.
      send_pixel(8'h5A, 1'b0, 1'b1, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
      // The first frame after reset is one pixel long and only records its time.
      send_frame(BASE_TIME, 16'h0000, 1, FILL_FULL, 1'b1);
      // After exactly one interval this frame is taken. It fills the store with zeros
      // and becomes the cached frame.
      send_frame(BASE_TIME + 1000, 16'h0001, FRAME_DEPTH, FILL_ZERO, 1'b1);
      // One millisecond short of the interval, so this frame is not taken.
      send_frame(BASE_TIME + 1999, 16'h0002, 1, FILL_ZERO, 1'b1);
      // Every pixel jumps from 0 to 255. Movement opens an event.
      send_frame(BASE_TIME + 2000, 16'hFFFF, FRAME_DEPTH, FILL_FULL, 1'b1);
      // The time goes backwards, so this frame is not taken.
      send_frame(BASE_TIME + 5, 16'h0003, 1, FILL_ZERO, 1'b1);
      // A quiet frame while the young event is open is passed through.
      send_frame(BASE_TIME + 3000, 16'h0004, FRAME_DEPTH, FILL_FULL, 1'b1);
      // A taken frame is cut off after one pixel. The next frame restarts and only
      // rebuilds the cache.
      send_frame(BASE_TIME + 4000, 16'h0005, 1, FILL_ZERO, 1'b0);
      send_frame(BASE_TIME + 7000, 16'h0006, FRAME_DEPTH, FILL_FULL, 1'b1);
      // Quiet, and the event is now 6000 ms old, so it closes.
      send_frame(BASE_TIME + 8000, 16'h0007, FRAME_DEPTH, FILL_FULL, 1'b1);
      // One pixel too many. The frame is dropped and the cache is invalidated.
      send_frame(BASE_TIME + 9000, 16'h0008, FRAME_DEPTH + 1, FILL_FULL, 1'b1);
      stamp = BASE_TIME + 9000;

      // Random part. Each phase first drains the block and then sets all three registers.
      // The first phases use the extremes. The third phase is the back-pressure test.
      phase = 0;
      while (random_pixels < ITEM_TARGET) begin
         if (!high_time_done && random_pixels >= ITEM_TARGET - 300) begin
            // A forward jump into the top of the time range, so the high time bits toggle.
            stamp = {16'hF000, 32'($urandom)};
            high_time_done = 1'b1;
         end
         case (phase)
            0: program_registers(32'd0, 32'd0, 32'd0);
            1: program_registers(32'hFFFF_FFFF, 32'd65536, 32'hFFFF_FFFF);
            2: begin
               // Once the cached count is one, each one-pixel frame gives a result: with
               // no interval and a zero threshold, every frame is taken and counts as
               // moving. The receiver holds off while the sender streams without gaps.
               program_registers(32'd0, 32'd0, $urandom_range(0, 20));
               hold_off_request = 1'b1;
               gaps_on = 1'b0;
               repeat (60) begin
                  send_frame(stamp, SLOT_W'($urandom), 1, FILL_RANDOM, 1'b1);
                  random_pixels++;
               end
            end
            default: begin
               logic [CSR_DATA_W-1:0] interval;
               logic [CSR_DATA_W-1:0] threshold;
               logic [CSR_DATA_W-1:0] duration;
               case ($urandom_range(0, 3))
                  0: interval = 32'd0;
                  1: interval = $urandom_range(1, 20);
                  2: interval = $urandom_range(100, 5000);
                  default: interval = 32'hFFFF_FFFF;
               endcase
               case ($urandom_range(0, 4))
                  0: threshold = 32'd0;
                  1: threshold = 32'd65536;
                  2: threshold = $urandom_range(0, 65536);
                  default: threshold = $urandom_range(200, 2000);
               endcase
               case ($urandom_range(0, 3))
                  0: duration = 32'd0;
                  1: duration = $urandom_range(1, 50);
                  2: duration = 32'hFFFF_FFFF;
                  default: duration = $urandom;
               endcase
               program_registers(interval, threshold, duration);
            end
         endcase
         if (phase != 2) run_frames(40, (phase % 3) != 1);
         phase++;
      end

      drain_results(SETTLE_CYCLES);
      tracker.flush_expectations();
      $display("covered %0d frames over %0d random pixels: %0d cut off, %0d oversize",
               tracker.frames_begun, random_pixels, tracker.frames_cut,
               tracker.frames_oversize);
      $display("compared %0d results: %0d event starts, %0d event stops, %0d frames passed",
               tracker.checked, tracker.starts, tracker.stops, tracker.passes);
      if (tracker.errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
